>>> src/twn_pkg.sv
// twn_pkg: shared types, constants and codes of the tone, wave and noise mixer
// no dependencies; imported by twn_step, twn_seq and the top module
package twn_pkg;

  localparam int WAVE_DEPTH_DEF  = 4096;
  localparam int VOICE_COUNT_DEF = 4;
  localparam int TONE_COUNT_DEF  = 2;

  localparam int HZ_W     = 16;
  localparam int PHASE_W  = 32;
  localparam int POS_W    = 48;
  localparam int IDX_W    = 16;
  localparam int LIM_W    = 17;
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int VOL_W    = 8;
  localparam int VOICE_W  = 26;
  localparam int LEN_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int NOISE_W  = 16;
  localparam int ACC_W    = 20;
  localparam int CFG_IDX_W = 4;

  // step = floor(hz * 2^32 / 48000) = (hz * STEP_K) >> 25, exact for 16-bit hz
  localparam int KP_W       = 21;
  localparam int STEP_SHIFT = 25;
  localparam logic [2*KP_W-1:0] STEP_K = 42'h2BB_0CF8_7D9D;

  localparam int TONE_AMP   = 4000;
  localparam int WAVE_BIAS  = 128;
  localparam int WAVE_GAIN  = 48;
  localparam int SIG_AMP    = 128;
  localparam int TRI_MID    = 256;
  localparam int TRI_TOP    = 383;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam logic [NOISE_W-1:0] NOISE_TAPS  = 16'hB400;
  localparam logic [NOISE_W-1:0] NOISE_RESET = 16'h0001;

  localparam logic [1:0] FORM_TRI   = 2'd2;
  localparam logic [1:0] FORM_NOISE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_A    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_A   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_RATE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LEN  = 4'd7;
  localparam int CFG_TONE_REGS  = 2;
  localparam int CFG_VOICE_REGS = 4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ADD,
    ST_APPLY,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic idle;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic apply;
    logic done;
  } seq_ctrl_t;

endpackage

>>> src/twn_ram.sv
// twn_ram: generic single-write, single-read memory with registered read data
// no dependencies
module twn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/twn_step.sv
// twn_step: shared phase step unit, one 16x21 multiplier used twice per step
// depends on twn_pkg for widths, the step constant and the control struct
module twn_step
  import twn_pkg::*;
(
  input  logic               clk_i,
  input  seq_ctrl_t          ctrl_i,
  input  logic [HZ_W-1:0]    hz_i,
  output logic [PHASE_W-1:0] step_o
);

  localparam int PROD_W = HZ_W + KP_W;
  localparam int SUM_W  = PROD_W + KP_W;

  logic [KP_W-1:0]    kop;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  lo_q;
  logic [PROD_W-1:0]  hi_q;
  logic [SUM_W-1:0]   sum;
  logic [PHASE_W-1:0] step_q;

  assign kop  = ctrl_i.mul_hi ? STEP_K[2*KP_W-1:KP_W] : STEP_K[KP_W-1:0];
  assign prod = PROD_W'(hz_i) * PROD_W'(kop);
  assign sum  = {hi_q, KP_W'(0)} + SUM_W'(lo_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_lo) begin
      lo_q <= prod;
    end
    if (ctrl_i.mul_hi) begin
      hi_q <= prod;
    end
    if (ctrl_i.add) begin
      step_q <= sum[STEP_SHIFT+PHASE_W-1:STEP_SHIFT];
    end
  end

  assign step_o = step_q;

endmodule

>>> src/twn_seq.sv
// twn_seq: sequencer that walks every source of a tick through the step unit
// depends on twn_pkg for the state enum and the control struct
module twn_seq
  import twn_pkg::*;
#(
  parameter int NSRC = TONE_COUNT_DEF + VOICE_COUNT_DEF + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    out_free_i,
  output seq_ctrl_t               ctrl_o,
  output logic [$clog2(NSRC)-1:0] src_o
);

  localparam int SRC_W = $clog2(NSRC);

  seq_state_e       state_q, state_d;
  logic [SRC_W-1:0] src_q, src_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      src_q   <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_LO;
          src_d   = '0;
        end
      end
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_ADD;
      ST_ADD: state_d = ST_APPLY;
      ST_APPLY: begin
        if (src_q == SRC_W'(NSRC - 1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LO;
          src_d   = src_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:  ctrl_o.idle   = 1'b1;
      ST_LO:    ctrl_o.mul_lo = 1'b1;
      ST_HI:    ctrl_o.mul_hi = 1'b1;
      ST_ADD:   ctrl_o.add    = 1'b1;
      ST_APPLY: ctrl_o.apply  = 1'b1;
      ST_DONE:  ctrl_o.done   = out_free_i;
      default:  ctrl_o = '0;
    endcase
  end

  assign src_o = src_q;

endmodule

>>> src/tone_wave_noise_sound_mixer_top.sv
// tone_wave_noise_sound_mixer_top: square tones, one-shot wave and four voices
// mixed into one saturated 16-bit sample per tick beat
// depends on twn_pkg, twn_seq, twn_step and twn_ram
//
// A tick beat is taken only while the sequencer is idle and then occupies the
// block until its sample is handed on: each source, in the order tones, wave,
// voices, passes through the one shared step multiplier (two partial products,
// one add) and one apply step; after the last source the sample goes to the
// output register. Write, start and stop beats are taken while idle and give
// no result. The output register lets the next beat in while a sample waits;
// a tick ends only once that register is free. Wave bytes live in a WAVE_DEPTH
// x 8 memory with registered read; bytes never written read back as unknown.
module tone_wave_noise_sound_mixer_top
  import twn_pkg::*;
#(
  parameter int WAVE_DEPTH  = WAVE_DEPTH_DEF,
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  parameter int TONE_COUNT  = TONE_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [23:0]          s_axis_tdata_i,   // wave_address[11:0], wave_byte[19:12]
  input  logic [1:0]           s_axis_tuser_i,   // op[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [23:0]          m_axis_tdata_o,   // sample[15:0], wave_playing[16]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VOICE_W-1:0]   cfg_data_i
);

  localparam int NSRC  = TONE_COUNT + VOICE_COUNT + 1;
  localparam int SRC_W = $clog2(NSRC);
  localparam int AW    = $clog2(WAVE_DEPTH);

  seq_ctrl_t          ctrl;
  logic [SRC_W-1:0]   src;
  logic [PHASE_W-1:0] step;
  logic               in_accept;
  op_e                in_op;
  logic [ADDR_W-1:0]  in_addr;
  logic [BYTE_W-1:0]  in_byte;
  logic               out_free;
  logic               cfg_we;

  logic [HZ_W-1:0]    tone_hz_q [TONE_COUNT];
  logic [VOICE_W-1:0] voice_q [VOICE_COUNT];
  logic [HZ_W-1:0]    wave_rate_q;
  logic [LEN_W-1:0]   wave_len_q;

  logic [PHASE_W-1:0] tone_phase_q [TONE_COUNT];
  logic [PHASE_W-1:0] voice_phase_q [VOICE_COUNT];
  logic [NOISE_W-1:0] noise_q;
  logic [POS_W-1:0]   wave_pos_q;
  logic               wave_active_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic               out_play_q;

  logic [HZ_W-1:0]    hz_sel;
  logic [PHASE_W-1:0] tone_phase_sel;
  logic [VOICE_W-1:0] voice_sel;
  logic [PHASE_W-1:0] voice_phase_sel;
  logic               is_tone;
  logic               is_wave;

  logic               tone_on;
  logic signed [ACC_W-1:0] tone_add;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]   w_idx;
  logic [LIM_W-1:0]   w_limit;
  logic               w_in;
  logic signed [9:0]  w_dev;
  logic signed [ACC_W-1:0] w_add;

  logic [HZ_W-1:0]    v_hz;
  logic [VOL_W-1:0]   v_vol;
  logic [1:0]         v_form;
  logic               v_on;
  logic [PHASE_W-1:0] v_phase_new;
  logic [8:0]         v_ramp;
  logic signed [9:0]  v_sig;
  logic [NOISE_W-1:0] noise_new;
  logic signed [18:0] v_prod;
  logic signed [18:0] v_half;
  logic signed [ACC_W-1:0] v_add;

  logic [SAMPLE_W-1:0] sat_sample;

  twn_seq #(
    .NSRC (NSRC)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept && in_op == OP_TICK),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .src_o      (src)
  );

  twn_step u_step (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .hz_i   (hz_sel),
    .step_o (step)
  );

  twn_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WAVE_DEPTH)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte),
    .raddr_i (w_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = ctrl.idle;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op           = op_e'(s_axis_tuser_i);
  assign in_addr         = s_axis_tdata_i[11:0];
  assign in_byte         = s_axis_tdata_i[19:12];
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign cfg_we          = cfg_valid_i && cfg_ready_o;

  assign ram_we    = in_accept && in_op == OP_WRITE && LIM_W'(in_addr) < LIM_W'(WAVE_DEPTH);
  assign ram_waddr = AW'(in_addr);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        tone_hz_q[k] <= '0;
      end
      for (int k = 0; k < VOICE_COUNT; k++) begin
        voice_q[k] <= '0;
      end
      wave_rate_q <= '0;
      wave_len_q  <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        if (k < CFG_TONE_REGS && cfg_index_i == CFG_TONE_A + CFG_IDX_W'(k)) begin
          tone_hz_q[k] <= cfg_data_i[HZ_W-1:0];
        end
      end
      for (int k = 0; k < VOICE_COUNT; k++) begin
        if (k < CFG_VOICE_REGS && cfg_index_i == CFG_VOICE_A + CFG_IDX_W'(k)) begin
          voice_q[k] <= cfg_data_i;
        end
      end
      if (cfg_index_i == CFG_WAVE_RATE) begin
        wave_rate_q <= cfg_data_i[HZ_W-1:0];
      end
      if (cfg_index_i == CFG_WAVE_LEN) begin
        wave_len_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  // source select
  always_comb begin
    hz_sel          = wave_rate_q;
    tone_phase_sel  = '0;
    voice_sel       = '0;
    voice_phase_sel = '0;
    for (int k = 0; k < TONE_COUNT; k++) begin
      if (src == SRC_W'(k)) begin
        hz_sel         = tone_hz_q[k];
        tone_phase_sel = tone_phase_q[k];
      end
    end
    for (int k = 0; k < VOICE_COUNT; k++) begin
      if (src == SRC_W'(TONE_COUNT + 1 + k)) begin
        hz_sel          = voice_q[k][HZ_W-1:0];
        voice_sel       = voice_q[k];
        voice_phase_sel = voice_phase_q[k];
      end
    end
  end

  assign is_tone = src < SRC_W'(TONE_COUNT);
  assign is_wave = src == SRC_W'(TONE_COUNT);

  // tone
  assign tone_on  = step != '0;
  assign tone_add = tone_phase_sel[PHASE_W-1] ? -ACC_W'(TONE_AMP) : ACC_W'(TONE_AMP);

  // wave
  assign w_idx   = wave_pos_q[POS_W-1:POS_W-IDX_W];
  assign w_limit = (LIM_W'(wave_len_q) > LIM_W'(WAVE_DEPTH)) ? LIM_W'(WAVE_DEPTH)
                                                            : LIM_W'(wave_len_q);
  assign w_in    = LIM_W'(w_idx) < w_limit;
  assign w_dev   = $signed({2'b00, ram_rdata}) - $signed(10'(WAVE_BIAS));
  assign w_add   = ACC_W'(w_dev) * $signed(ACC_W'(WAVE_GAIN));

  // voice
  assign v_hz        = voice_sel[HZ_W-1:0];
  assign v_vol       = voice_sel[HZ_W+VOL_W-1:HZ_W];
  assign v_form      = voice_sel[VOICE_W-1:HZ_W+VOL_W];
  assign v_on        = v_hz != '0 && v_vol != '0;
  assign v_phase_new = voice_phase_sel + step;
  assign v_ramp      = v_phase_new[PHASE_W-1:PHASE_W-9];
  assign noise_new   = (noise_q >> 1) ^ (noise_q[0] ? NOISE_TAPS : '0);

  always_comb begin
    case (v_form)
      FORM_TRI: begin
        if (10'(v_ramp) < 10'(TRI_MID)) begin
          v_sig = $signed(10'(v_ramp)) - $signed(10'(SIG_AMP));
        end else begin
          v_sig = $signed(10'(TRI_TOP)) - $signed(10'(v_ramp));
        end
      end
      FORM_NOISE: v_sig = noise_new[0] ? $signed(10'(SIG_AMP)) : -$signed(10'(SIG_AMP));
      default: begin
        v_sig = v_phase_new[PHASE_W-1] ? -$signed(10'(SIG_AMP)) : $signed(10'(SIG_AMP));
      end
    endcase
  end

  // halve toward zero
  assign v_prod = 19'(v_sig) * $signed({11'b0, v_vol});
  assign v_half = (v_prod + $signed({18'b0, v_prod[18]})) >>> 1;
  assign v_add  = ACC_W'(v_half);

  // mixer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        tone_phase_q[k] <= '0;
      end
      for (int k = 0; k < VOICE_COUNT; k++) begin
        voice_phase_q[k] <= '0;
      end
      noise_q       <= NOISE_RESET;
      wave_pos_q    <= '0;
      wave_active_q <= 1'b0;
      acc_q         <= '0;
    end else begin
      if (in_accept) begin
        case (in_op)
          OP_TICK:  acc_q <= '0;
          OP_START: begin
            if (wave_rate_q != '0 && wave_len_q != '0) begin
              wave_pos_q    <= '0;
              wave_active_q <= 1'b1;
            end
          end
          OP_STOP:  wave_active_q <= 1'b0;
          default:  ;
        endcase
      end
      if (ctrl.apply) begin
        if (is_tone) begin
          if (tone_on) begin
            acc_q <= acc_q + tone_add;
            for (int k = 0; k < TONE_COUNT; k++) begin
              if (src == SRC_W'(k)) begin
                tone_phase_q[k] <= tone_phase_sel + step;
              end
            end
          end
        end else if (is_wave) begin
          if (wave_active_q) begin
            if (w_in) begin
              acc_q      <= acc_q + w_add;
              wave_pos_q <= wave_pos_q + POS_W'(step);
            end else begin
              wave_active_q <= 1'b0;
            end
          end
        end else if (v_on) begin
          acc_q <= acc_q + v_add;
          if (v_form == FORM_NOISE) begin
            noise_q <= noise_new;
          end
          for (int k = 0; k < VOICE_COUNT; k++) begin
            if (src == SRC_W'(TONE_COUNT + 1 + k)) begin
              voice_phase_q[k] <= v_phase_new;
            end
          end
        end
      end
    end
  end

  // saturate to signed 16 bits
  always_comb begin
    if (acc_q > $signed(ACC_W'(SAMPLE_MAX))) begin
      sat_sample = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc_q < $signed(ACC_W'(SAMPLE_MIN))) begin
      sat_sample = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sat_sample = acc_q[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      out_sample_q <= sat_sample;
      out_play_q   <= wave_active_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_play_q, out_sample_q};

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctrl.done))
    else $error("output beat raised without a finished tick");

  a_wave_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wave_active_q) |-> $past(in_accept && in_op == OP_START))
    else $error("wave became active without a start beat");

  a_noise_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_q != '0)
    else $error("noise register locked at zero");

endmodule
